// File: rtl/task_ready_queue_manager_core_assert.svh
// Assertion macros used by the queue manager controller.
`ifndef TASK_READY_QUEUE_MANAGER_CORE_ASSERT_SVH
`define TASK_READY_QUEUE_MANAGER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define TRQM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trqm assertion failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define TRQM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trqm assertion failed");

`endif

// File: rtl/trqm_pkg.sv
// Shared constants, opcodes, command codes and status type of the queue manager.
package trqm_pkg;

  localparam int TASK_COUNT_DEF  = 16;
  localparam int QUEUE_COUNT_DEF = 8;
  localparam int KEY_BITS_DEF    = 32;

  localparam int OP_W    = 3;
  localparam int QIN_W   = 3;
  localparam int TIN_W   = 4;
  localparam int KIN_W   = 32;
  localparam int POP_W   = 4;
  localparam int IN_DW   = 48;
  localparam int OUT_DW  = 8;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_SORTED     = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
  localparam logic [OP_W-1:0] OP_POP        = 3'd4;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_HT,
    CMD_POP_SET,
    CMD_SET_EMPTY,
    CMD_RD_T,
    CMD_RM,
    CMD_KEY_WR,
    CMD_PB1,
    CMD_PB2,
    CMD_PF1,
    CMD_PF2,
    CMD_WALK_RD,
    CMD_WALK_ADV,
    CMD_INS_RD,
    CMD_INS_WR1,
    CMD_INS_WR2,
    CMD_RES_LD
  } cmd_e;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            q_ok;
    logic            t_ok;
    logic            h_task;
    logic            empty;
    logic            node_task;
    logic            steps_done;
    logic            steps_zero;
    logic            key_gt;
  } dp_status_t;

endpackage

// File: rtl/trqm_dp.sv
// Datapath: link, key and head/tail stores plus the working registers of one word.
module trqm_dp import trqm_pkg::*; #(
  parameter int TASK_COUNT  = TASK_COUNT_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_e              cmd_i,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [QIN_W-1:0]  queue_index_i,
  input  logic [TIN_W-1:0]  task_id_i,
  input  logic [KIN_W-1:0]  sort_key_i,
  output dp_status_t        status_o,
  output logic [POP_W-1:0]  popped_task_o,
  output logic              status_bit_o
);

  localparam int LW  = $clog2(TASK_COUNT + 1);
  localparam int TIW = $clog2(TASK_COUNT);
  localparam int QW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int SW  = $clog2(TASK_COUNT + 1);
  localparam logic [LW-1:0] NIL = LW'(TASK_COUNT);

  // stores
  logic [LW-1:0]       next_mem [TASK_COUNT];
  logic [LW-1:0]       prev_mem [TASK_COUNT];
  logic [KEY_BITS-1:0] key_mem  [TASK_COUNT];
  logic [LW-1:0]       head_mem [QUEUE_COUNT];
  logic [LW-1:0]       tail_mem [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] head_vld_q, tail_vld_q;

  // working registers
  logic [OP_W-1:0]     op_q;
  logic [QW-1:0]       q_q;
  logic                q_ok_q, t_ok_q;
  logic [TIW-1:0]      t_q;
  logic [KEY_BITS-1:0] key_q;
  logic [LW-1:0]       hd_q, tl_q, node_q;
  logic [SW-1:0]       steps_q;
  logic [LW-1:0]       nxt_rd_q, prv_rd_q;
  logic [KEY_BITS-1:0] key_rd_q;
  logic [POP_W-1:0]    popped_q;
  logic                stat_q;

  // result register
  logic [POP_W-1:0]    res_task_q;
  logic                res_stat_q;

  // write ports
  logic                next_we, prev_we, key_we, hd_we, tl_we;
  logic [TIW-1:0]      next_wa, prev_wa;
  logic [LW-1:0]       next_wd, prev_wd, hd_wd, tl_wd;
  logic [TIW-1:0]      rd_addr;

  logic [LW-1:0] t_l;
  logic          at_head, at_tail, empty;
  logic [LW-1:0] p_eff;

  assign t_l     = LW'(t_q);
  assign empty   = (hd_q == NIL) && (tl_q == NIL);
  assign at_head = (hd_q == t_l);
  assign at_tail = (tl_q == t_l);
  assign p_eff   = (at_head && (nxt_rd_q == t_l)) ? NIL : prv_rd_q;

  // one read address for the link and key stores
  always_comb begin
    case (cmd_i)
      CMD_RD_T: rd_addr = t_q;
      default:  rd_addr = node_q[TIW-1:0];
    endcase
  end

  // write port selection per command
  always_comb begin
    next_we = 1'b0; next_wa = t_q; next_wd = NIL;
    prev_we = 1'b0; prev_wa = t_q; prev_wd = NIL;
    key_we  = 1'b0;
    hd_we   = 1'b0; hd_wd = t_l;
    tl_we   = 1'b0; tl_wd = t_l;
    case (cmd_i)
      CMD_KEY_WR: key_we = 1'b1;
      CMD_RM: begin
        prev_we = (nxt_rd_q < NIL) && (at_head || !at_tail);
        prev_wa = nxt_rd_q[TIW-1:0];
        prev_wd = at_head ? NIL : prv_rd_q;
        next_we = (p_eff < NIL) && (at_tail || !at_head);
        next_wa = p_eff[TIW-1:0];
        next_wd = at_tail ? NIL : nxt_rd_q;
        hd_we   = at_head;
        hd_wd   = nxt_rd_q;
        tl_we   = at_tail;
        tl_wd   = p_eff;
      end
      CMD_PB1: begin
        hd_we   = empty;
        prev_we = 1'b1;
        prev_wd = empty ? NIL : tl_q;
        next_we = !empty && (tl_q < NIL);
        next_wa = tl_q[TIW-1:0];
        next_wd = t_l;
        tl_we   = 1'b1;
      end
      CMD_PB2: next_we = 1'b1;
      CMD_PF1: begin
        tl_we   = empty;
        next_we = 1'b1;
        next_wd = empty ? NIL : hd_q;
        prev_we = !empty && (hd_q < NIL);
        prev_wa = hd_q[TIW-1:0];
        prev_wd = t_l;
        hd_we   = 1'b1;
      end
      CMD_PF2: prev_we = 1'b1;
      CMD_INS_WR1: begin
        next_we = (prv_rd_q < NIL);
        next_wa = prv_rd_q[TIW-1:0];
        next_wd = t_l;
        prev_we = 1'b1;
        prev_wd = prv_rd_q;
      end
      CMD_INS_WR2: begin
        next_we = 1'b1;
        next_wd = node_q;
        prev_we = 1'b1;
        prev_wa = node_q[TIW-1:0];
        prev_wd = t_l;
      end
      default: begin
      end
    endcase
  end

  // link and key stores, registered reads
  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (key_we)  key_mem[t_q] <= key_q;
    if (hd_we)   head_mem[q_q] <= hd_wd;
    if (tl_we)   tail_mem[q_q] <= tl_wd;
    nxt_rd_q <= next_mem[rd_addr];
    prv_rd_q <= prev_mem[rd_addr];
    key_rd_q <= key_mem[rd_addr];
  end

  // head/tail valid bits: an unwritten entry reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      tail_vld_q <= '0;
    end else begin
      if (hd_we) head_vld_q[q_q] <= 1'b1;
      if (tl_we) tail_vld_q[q_q] <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q     <= opcode_i;
        q_ok_q   <= (32'(queue_index_i) < QUEUE_COUNT);
        q_q      <= (32'(queue_index_i) < QUEUE_COUNT) ? QW'(queue_index_i) : '0;
        t_ok_q   <= (32'(task_id_i) < TASK_COUNT);
        t_q      <= (32'(task_id_i) < TASK_COUNT) ? TIW'(task_id_i) : '0;
        key_q    <= KEY_BITS'(sort_key_i);
        popped_q <= '0;
        stat_q   <= 1'b0;
      end
      CMD_RD_HT: begin
        hd_q <= head_vld_q[q_q] ? head_mem[q_q] : NIL;
        tl_q <= tail_vld_q[q_q] ? tail_mem[q_q] : NIL;
      end
      CMD_POP_SET: begin
        popped_q <= POP_W'(hd_q);
        t_q      <= hd_q[TIW-1:0];
      end
      CMD_SET_EMPTY: stat_q <= 1'b1;
      CMD_KEY_WR: begin
        node_q  <= hd_q;
        steps_q <= '0;
      end
      CMD_WALK_ADV: begin
        node_q  <= nxt_rd_q;
        steps_q <= steps_q + SW'(1);
      end
      CMD_RES_LD: begin
        res_task_q <= popped_q;
        res_stat_q <= stat_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.op         = op_q;
  assign status_o.q_ok       = q_ok_q;
  assign status_o.t_ok       = t_ok_q;
  assign status_o.h_task     = (hd_q < NIL);
  assign status_o.empty      = empty;
  assign status_o.node_task  = (node_q < NIL);
  assign status_o.steps_done = (steps_q == SW'(TASK_COUNT));
  assign status_o.steps_zero = (steps_q == '0);
  assign status_o.key_gt     = (key_q > key_rd_q);

  assign popped_task_o = res_task_q;
  assign status_bit_o  = res_stat_q;

endmodule

// File: rtl/trqm_ctrl.sv
// Controller: sequences one word through reads, link updates and the result handshake.
module trqm_ctrl import trqm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  `include "task_ready_queue_manager_core_assert.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDHT = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_RDT  = 4'd3;
  localparam logic [3:0] S_RM   = 4'd4;
  localparam logic [3:0] S_KEY  = 4'd5;
  localparam logic [3:0] S_PB1  = 4'd6;
  localparam logic [3:0] S_PB2  = 4'd7;
  localparam logic [3:0] S_PF1  = 4'd8;
  localparam logic [3:0] S_PF2  = 4'd9;
  localparam logic [3:0] S_WRD  = 4'd10;
  localparam logic [3:0] S_WCK  = 4'd11;
  localparam logic [3:0] S_IRD  = 4'd12;
  localparam logic [3:0] S_IWR1 = 4'd13;
  localparam logic [3:0] S_IWR2 = 4'd14;
  localparam logic [3:0] S_RES  = 4'd15;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       res_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  // result register is free now or emptied at this edge
  assign res_load    = (state_q == S_RES) && (!out_valid_q || out_ready_i);

  // next state and datapath command
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o   = CMD_LOAD;
          state_d = S_RDHT;
        end
      end
      S_RDHT: begin
        cmd_o   = CMD_RD_HT;
        state_d = S_CHK;
      end
      S_CHK: begin
        case (status_i.op)
          OP_POP: begin
            if (!status_i.q_ok || !status_i.h_task) begin
              cmd_o   = CMD_SET_EMPTY;
              state_d = S_RES;
            end else begin
              cmd_o   = CMD_POP_SET;
              state_d = S_RDT;
            end
          end
          OP_REMOVE: begin
            if (!status_i.q_ok || !status_i.t_ok || status_i.empty) state_d = S_RES;
            else state_d = S_RDT;
          end
          OP_PUSH_BACK, OP_PUSH_FRONT, OP_SORTED: begin
            if (!status_i.q_ok || !status_i.t_ok) state_d = S_RES;
            else state_d = S_KEY;
          end
          default: state_d = S_RES;
        endcase
      end
      S_RDT: begin
        cmd_o   = CMD_RD_T;
        state_d = S_RM;
      end
      S_RM: begin
        cmd_o   = CMD_RM;
        state_d = S_RES;
      end
      S_KEY: begin
        cmd_o = CMD_KEY_WR;
        case (status_i.op)
          OP_PUSH_BACK:  state_d = S_PB1;
          OP_PUSH_FRONT: state_d = S_PF1;
          default:       state_d = S_WRD;
        endcase
      end
      S_PB1: begin
        cmd_o   = CMD_PB1;
        state_d = S_PB2;
      end
      S_PB2: begin
        cmd_o   = CMD_PB2;
        state_d = S_RES;
      end
      S_PF1: begin
        cmd_o   = CMD_PF1;
        state_d = S_PF2;
      end
      S_PF2: begin
        cmd_o   = CMD_PF2;
        state_d = S_RES;
      end
      // walk: fetch key and link of the current node
      S_WRD: begin
        if (!status_i.node_task) begin
          state_d = status_i.steps_zero ? S_PF1 : S_PB1;
        end else if (status_i.steps_done) begin
          state_d = S_PB1;
        end else begin
          cmd_o   = CMD_WALK_RD;
          state_d = S_WCK;
        end
      end
      S_WCK: begin
        if (status_i.key_gt) begin
          cmd_o   = CMD_WALK_ADV;
          state_d = S_WRD;
        end else begin
          state_d = status_i.steps_zero ? S_PF1 : S_IRD;
        end
      end
      S_IRD: begin
        cmd_o   = CMD_INS_RD;
        state_d = S_IWR1;
      end
      S_IWR1: begin
        cmd_o   = CMD_INS_WR1;
        state_d = S_IWR2;
      end
      S_IWR2: begin
        cmd_o   = CMD_INS_WR2;
        state_d = S_RES;
      end
      // hold the finished word until the result register can take it
      S_RES: begin
        if (res_load) begin
          cmd_o   = CMD_RES_LD;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result valid: set when the result register loads, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (res_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TRQM_ASSERT_NEXT(a_accept_reads, accept, state_q == S_RDHT)
  `TRQM_ASSERT_NEXT(a_res_valid, res_load, out_valid_q)
  `TRQM_ASSERT_NOW(a_ready_idle, in_ready_o, state_q == S_IDLE)
  `TRQM_ASSERT_NOW(a_wck_after_wrd, state_q == S_WCK, $past(state_q) == S_WRD)

endmodule

// File: rtl/task_ready_queue_manager_core.sv
// Steps from accept to result: an empty pop, a bad index or an unknown opcode goes from the
// check straight to the result; remove and pop read the task's links and unlink it; push
// back/front write key and links; a sorted insert walks the queue up to the task limit.
// Throughput: one word at a time; a finished word waits while the result register is full.
// The result register lets the next word in while a result waits to be taken.
// Reset: asynchronous active low; all queues empty, link and key stores left as is.
module task_ready_queue_manager_core import trqm_pkg::*; #(
  parameter int TASK_COUNT  = TASK_COUNT_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode[2:0], queue_index[5:3], task_id[9:6], sort_key[41:10], zero pad
  input  logic [IN_DW-1:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // popped_task[3:0], status[4], zero pad
  output logic [OUT_DW-1:0] m_axis_tdata
);

  cmd_e             cmd;
  dp_status_t       dp_status;
  logic [POP_W-1:0] popped_task;
  logic             status_bit;

  trqm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  trqm_dp #(
    .TASK_COUNT  (TASK_COUNT),
    .QUEUE_COUNT (QUEUE_COUNT),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (s_axis_tdata[2:0]),
    .queue_index_i (s_axis_tdata[5:3]),
    .task_id_i     (s_axis_tdata[9:6]),
    .sort_key_i    (s_axis_tdata[41:10]),
    .status_o      (dp_status),
    .popped_task_o (popped_task),
    .status_bit_o  (status_bit)
  );

  assign m_axis_tdata = {3'b000, status_bit, popped_task};

endmodule
